FILE: sv/cbpl_pkg.sv
// shared types, widths and helpers for the cubic bezier point and length block
// no dependencies; imported by every module of the block
package cbpl_pkg;

  localparam int SAMPLE_COUNT = 128;
  localparam int COORD_BITS   = 11;

  localparam int REG_COUNT = 8;
  localparam int REG_IDX_W = 3;

  // fixed point parameter format and the truncating square and cube
  localparam int T_W        = 19;
  localparam int T_FRAC     = 18;
  localparam int PRE_SHIFT  = 3;
  localparam int POST_SHIFT = 12;
  localparam int TS_W       = T_W - PRE_SHIFT;
  localparam int T2_W       = 2 * TS_W - POST_SHIFT;
  localparam int T2S_W      = T2_W - PRE_SHIFT;
  localparam int T3_W       = T2S_W + TS_W - POST_SHIFT;

  // power-basis coefficients need five bits beyond a coordinate
  localparam int COEF_W = COORD_BITS + 5;

  // shared multiplier operands and product
  localparam int MA_W   = 18;
  localparam int MB_W   = 22;
  localparam int PROD_W = MA_W + MB_W;
  localparam int EV_W   = PROD_W - T_FRAC;

  localparam int DX_W   = 16;
  localparam int SQ_W   = 32;
  localparam int ROOT_W = SQ_W / 2;

  localparam int CNT_W = $clog2(SAMPLE_COUNT + 1);
  localparam int T_STEP = (1 << T_FRAC) / SAMPLE_COUNT;

  localparam int PT_W  = 12;
  localparam int LEN_W = 19;
  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
  localparam int TOT_W = (ROOT_W + CNT_W > LEN_W) ? ROOT_W + CNT_W : LEN_W + 1;

  // configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_START_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CTRL1_X = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CTRL1_Y = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CTRL2_X = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CTRL2_Y = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_END_X   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_END_Y   = 3'd7;

  localparam logic KIND_EVAL    = 1'b0;
  localparam logic KIND_MEASURE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_ROOT_WAIT,
    ST_FINISH
  } state_t;

  // micro steps of one curve evaluation on the shared multiplier
  typedef enum logic [3:0] {
    P_TSQ,
    P_TCUBE,
    P_AX,
    P_BX,
    P_CX,
    P_AY,
    P_BY,
    P_CY,
    P_YDONE,
    P_DX,
    P_DY,
    P_SQSUM,
    P_NEXT
  } step_t;

  typedef struct packed {
    logic signed [COEF_W-1:0]     a;
    logic signed [COEF_W-1:0]     b;
    logic signed [COEF_W-1:0]     c;
    logic signed [COORD_BITS-1:0] d;
  } coef_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

  function automatic coef_t calc_coef(
    input logic signed [COORD_BITS-1:0] p0,
    input logic signed [COORD_BITS-1:0] p1,
    input logic signed [COORD_BITS-1:0] p2,
    input logic signed [COORD_BITS-1:0] p3
  );
    logic signed [COEF_W-1:0] e0;
    logic signed [COEF_W-1:0] e1;
    logic signed [COEF_W-1:0] e2;
    logic signed [COEF_W-1:0] e3;
    logic signed [COEF_W-1:0] d1;
    logic signed [COEF_W-1:0] d2;
    coef_t r;
    e0 = COEF_W'(p0);
    e1 = COEF_W'(p1);
    e2 = COEF_W'(p2);
    e3 = COEF_W'(p3);
    d1 = e1 - e0;
    d2 = e2 - e1;
    r.c = d1 + (d1 <<< 1);
    r.b = d2 + (d2 <<< 1) - r.c;
    r.a = e3 - e0 - (d2 + (d2 <<< 1));
    r.d = p0;
    return r;
  endfunction

endpackage

FILE: sv/cbpl_mul.sv
// shared signed multiplier with a registered product
// depends on cbpl_pkg for operand widths
module cbpl_mul (
  input  logic                                clk,
  input  logic signed [cbpl_pkg::MA_W-1:0]    op_a,
  input  logic signed [cbpl_pkg::MB_W-1:0]    op_b,
  output logic signed [cbpl_pkg::PROD_W-1:0]  prod
);
  import cbpl_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_a) * PROD_W'(op_b);
  end

endmodule

FILE: sv/cbpl_isqrt.sv
// iterative floor square root, two radicand bits per cycle
// depends on cbpl_pkg for widths and the status struct
module cbpl_isqrt (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cbpl_pkg::SQ_W-1:0]     radicand,
  output logic [cbpl_pkg::ROOT_W-1:0]   root,
  output cbpl_pkg::sqrt_stat_t          stat
);
  import cbpl_pkg::*;

  logic [SQ_W-1:0] rem;
  logic [SQ_W-1:0] res;
  logic [SQ_W-1:0] bitm;
  logic [SQ_W:0]   trial;
  logic            take;
  logic            busy;
  logic            done;

  assign trial = {1'b0, res} + {1'b0, bitm};
  assign take  = {1'b0, rem} >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitm[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= radicand;
      res  <= '0;
      bitm <= {2'b01, {(SQ_W-2){1'b0}}};
    end else if (busy) begin
      if (take) begin
        rem <= rem - trial[SQ_W-1:0];
        res <= (res >> 1) + bitm;
      end else begin
        res <= res >> 1;
      end
      bitm <= bitm >> 2;
    end
  end

  assign root      = res[ROOT_W-1:0];
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: sv/cubic_bezier_point_and_length.sv
// cubic bezier point evaluation and sampled length, top level
// depends on cbpl_pkg, cbpl_mul and cbpl_isqrt
//
// Usage: the eight control coordinates are written through cfg_wr_en,
// cfg_index and cfg_data while the block is idle. An input word carries
// kind and t_param and is taken when in_valid is high and in_stall low;
// in_stall is high from the accept until the result sits in the output
// register. The result word is offered with out_valid and taken when
// out_stall is low; a word held by out_stall does not block the next
// input, only the end of that item's work.
// An evaluate word runs nine micro steps on the one shared multiplier
// plus the output load; the next word is taken at the earliest once
// the block is back in idle after the output load.
// A measure word runs SAMPLE_COUNT samples; each sample needs 13
// micro steps, and the sample rate is set by the 16-iteration square
// root that overlaps the next sample's math.
// Reset (rst, synchronous) clears the control registers to zero and
// drops out_valid; there is no clearing pass.
module cubic_bezier_point_and_length (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [cbpl_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [cbpl_pkg::COORD_BITS-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 kind,
  input  logic [cbpl_pkg::T_W-1:0]             t_param,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [cbpl_pkg::PT_W-1:0]     point_x,
  output logic signed [cbpl_pkg::PT_W-1:0]     point_y,
  output logic [cbpl_pkg::LEN_W-1:0]           length_sum
);
  import cbpl_pkg::*;

  logic signed [COORD_BITS-1:0] coord [REG_COUNT];

  state_t state;
  state_t state_next;
  step_t  step;

  logic accept;
  logic sq_start;
  logic ld_out;
  logic last_sample;

  logic                     is_measure;
  coef_t                    coef_x;
  coef_t                    coef_y;
  logic [T_W-1:0]           t;
  logic [T2_W-1:0]          t2;
  logic [T3_W-1:0]          t3;
  logic [CNT_W-1:0]         k;
  logic signed [PROD_W-1:0] acc;
  logic signed [EV_W-1:0]   x;
  logic signed [EV_W-1:0]   y;
  logic signed [EV_W-1:0]   xp;
  logic signed [EV_W-1:0]   yp;
  logic [SQ_W-1:0]          sq;
  logic [TOT_W-1:0]         tot;

  logic signed [MA_W-1:0]   op_a;
  logic signed [MB_W-1:0]   op_b;
  logic signed [PROD_W-1:0] prod;
  logic [ROOT_W-1:0]        root;
  sqrt_stat_t               sq_stat;

  logic [TS_W-1:0]            ts;
  logic [T2_W-1:0]            t2n;
  logic [T3_W-1:0]            t3n;
  logic signed [PROD_W-1:0]   acc_sum;
  logic signed [COORD_BITS-1:0] d_sel;
  logic signed [EV_W-1:0]     ev;
  logic signed [DX_W-1:0]     dx;
  logic signed [DX_W-1:0]     dy;
  logic [LEN_W-1:0]           len_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        coord[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      coord[cfg_index] <= cfg_data;
    end
  end

  cbpl_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  cbpl_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq),
    .root     (root),
    .stat     (sq_stat)
  );

  assign ts          = t[T_W-1:PRE_SHIFT];
  assign t2n         = prod[POST_SHIFT +: T2_W];
  assign t3n         = prod[POST_SHIFT +: T3_W];
  assign acc_sum     = acc + prod;
  assign d_sel       = (step == P_AY) ? coef_x.d : coef_y.d;
  // floor shift of the sum, then the constant term
  assign ev          = acc_sum[PROD_W-1:T_FRAC] + EV_W'(d_sel);
  assign dx          = DX_W'(x - xp);
  assign dy          = DX_W'(y - yp);
  assign last_sample = (k == CNT_W'(SAMPLE_COUNT));
  assign len_sat     = (tot > TOT_W'(LEN_MAX)) ? LEN_MAX : tot[LEN_W-1:0];

  // multiplier operand selection per micro step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step)
      P_TSQ: begin
        op_a = {{(MA_W-TS_W){1'b0}}, ts};
        op_b = {{(MB_W-TS_W){1'b0}}, ts};
      end
      P_TCUBE: begin
        op_a = {{(MA_W-T2S_W){1'b0}}, t2n[T2_W-1:PRE_SHIFT]};
        op_b = {{(MB_W-TS_W){1'b0}}, ts};
      end
      P_AX: begin
        op_a = MA_W'(coef_x.a);
        op_b = {{(MB_W-T3_W){1'b0}}, t3n};
      end
      P_BX: begin
        op_a = MA_W'(coef_x.b);
        op_b = {{(MB_W-T2_W){1'b0}}, t2};
      end
      P_CX: begin
        op_a = MA_W'(coef_x.c);
        op_b = {{(MB_W-T_W){1'b0}}, t};
      end
      P_AY: begin
        op_a = MA_W'(coef_y.a);
        op_b = {{(MB_W-T3_W){1'b0}}, t3};
      end
      P_BY: begin
        op_a = MA_W'(coef_y.b);
        op_b = {{(MB_W-T2_W){1'b0}}, t2};
      end
      P_CY: begin
        op_a = MA_W'(coef_y.c);
        op_b = {{(MB_W-T_W){1'b0}}, t};
      end
      P_DX: begin
        op_a = MA_W'(dx);
        op_b = MB_W'(dx);
      end
      P_DY: begin
        op_a = MA_W'(dy);
        op_b = MB_W'(dy);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_CALC;
      end
      ST_CALC: begin
        if (step == P_YDONE && !is_measure) begin
          state_next = ST_FINISH;
        end else if (step == P_NEXT && !sq_stat.busy && last_sample) begin
          state_next = ST_ROOT_WAIT;
        end
      end
      ST_ROOT_WAIT: begin
        if (!sq_stat.busy) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    sq_start = 1'b0;
    ld_out   = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_CALC: sq_start = (step == P_NEXT) && !sq_stat.busy;
      ST_ROOT_WAIT: ;
      ST_FINISH: ld_out = !out_valid || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= P_TSQ;
    end else begin
      state <= state_next;
      if (accept) begin
        step <= P_TSQ;
      end else if (state == ST_CALC) begin
        if (step == P_NEXT) begin
          if (sq_start) step <= P_TSQ;
        end else begin
          step <= step_t'(step + 4'd1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ld_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld_out) begin
      point_x    <= is_measure ? '0 : x[PT_W-1:0];
      point_y    <= is_measure ? '0 : y[PT_W-1:0];
      length_sum <= is_measure ? len_sat : '0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      is_measure <= kind;
      coef_x <= calc_coef(coord[REG_START_X], coord[REG_CTRL1_X],
                          coord[REG_CTRL2_X], coord[REG_END_X]);
      coef_y <= calc_coef(coord[REG_START_Y], coord[REG_CTRL1_Y],
                          coord[REG_CTRL2_Y], coord[REG_END_Y]);
      t   <= (kind == KIND_MEASURE) ? T_W'(T_STEP) : t_param;
      k   <= CNT_W'(1);
      xp  <= EV_W'(coord[REG_START_X]);
      yp  <= EV_W'(coord[REG_START_Y]);
      tot <= '0;
    end else begin
      if (sq_stat.done) tot <= tot + TOT_W'(root);
      if (state == ST_CALC) begin
        case (step)
          P_TCUBE: t2 <= t2n;
          P_AX:    t3 <= t3n;
          P_BX:    acc <= prod;
          P_CX:    acc <= acc_sum;
          P_AY:    x <= ev;
          P_BY:    acc <= prod;
          P_CY:    acc <= acc_sum;
          P_YDONE: y <= ev;
          P_DX:    xp <= x;
          P_DY: begin
            yp <= y;
            sq <= prod[SQ_W-1:0];
          end
          P_SQSUM: sq <= sq + prod[SQ_W-1:0];
          P_NEXT: begin
            if (sq_start && !last_sample) begin
              t <= t + T_W'(T_STEP);
              k <= k + CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // an accepted word always starts at the first micro step
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_CALC && step == P_TSQ)
    else $error("accepted word did not start the sequence");

  // a finished root belongs to a measure in progress
  a_root_in_measure: assert property (@(posedge clk) disable iff (rst)
    sq_stat.done |-> (state == ST_CALC || state == ST_ROOT_WAIT) && is_measure)
    else $error("square root finished outside a measure");

  // the last root is awaited only after the final sample
  a_root_wait_last: assert property (@(posedge clk) disable iff (rst)
    state == ST_ROOT_WAIT |-> last_sample)
    else $error("waiting for the root before the last sample");

  // a result carries either a point or a length
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> length_sum == '0 || (point_x == '0 && point_y == '0))
    else $error("result carries both a point and a length");

endmodule
